### hw/rtl/assert_macros.svh
// Assertion macros shared by the hashed page table RTL.
// No dependencies; compiled out when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain property, checked at every rising edge outside reset
`define HPT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication a |=> c, checked outside reset
`define HPT_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define HPT_ASSERT(label, clk, rst, prop, msg)
`define HPT_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

### hw/rtl/hpt_pkg.sv
// Shared types and constants of the hashed page table engine.
// No dependencies.
`default_nettype none
package hpt_pkg;

  localparam int EXTRA_INDEX_BITS_DEF = 2;
  localparam int ENTRIES_PER_GROUP    = 8;
  localparam int SLOT_W               = $clog2(ENTRIES_PER_GROUP);
  localparam int LOW_INDEX_BITS       = 10;
  localparam int PADDR_W              = 3;

  localparam logic [23:0] VSID_RESET = 24'h001000;

  // register index (paddr[2])
  localparam logic REG_HASH_MASK = 1'b0;

  // actions
  localparam logic [1:0] ACT_MAP     = 2'd0;
  localparam logic [1:0] ACT_UNMAP   = 2'd1;
  localparam logic [1:0] ACT_RESOLVE = 2'd2;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // one page entry as held in the group memory; protection is constant
  typedef struct packed {
    logic        valid;
    logic [23:0] vsid;
    logic        sec;
    logic [5:0]  api;
    logic [19:0] frame;
  } pte_t;

  typedef pte_t [ENTRIES_PER_GROUP-1:0] pte_row_t;

endpackage
`default_nettype wire

### hw/rtl/hpt_if.sv
// Valid/ready channel interfaces for request and response words.
// No dependencies.
`default_nettype none
interface hpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] virt_addr;
  logic [19:0] phys_page;

  modport source (output valid, action, virt_addr, phys_page, input ready);
  modport sink   (input valid, action, virt_addr, phys_page, output ready);
endinterface

interface hpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] result_page;

  modport source (output valid, status, result_page, input ready);
  modport sink   (input valid, status, result_page, output ready);
endinterface
`default_nettype wire

### hw/rtl/hashed_page_table_engine_top.sv
// Hashed page table engine: segment table in flops, page groups in one
// synchronous memory, one row of eight entries per group.
// Each word is read, compared and, on a hit for map or unmap, written back on
// the single group memory port: S_RD1 and S_CHK1 on the primary group, then
// S_RD2 and S_CHK2 on the secondary group when the primary has no candidate,
// and S_OUT to hand the response over. An unmap or resolve on an invalid segment,
// or an unknown action, goes straight to S_OUT; a new word is taken only in S_IDLE.
// Reset: synchronous; a clearing pass writes all 2**(10+EXTRA_INDEX_BITS) groups
// to zero and so empties the memory, requests are held off until it ends.
`default_nettype none
`include "assert_macros.svh"
module hashed_page_table_engine_top
  import hpt_pkg::*;
#(
  parameter int EXTRA_INDEX_BITS = EXTRA_INDEX_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  hpt_req_if.sink                 req,
  hpt_rsp_if.source               rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int GW          = LOW_INDEX_BITS + EXTRA_INDEX_BITS;
  localparam int GROUP_COUNT = 1 << GW;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD1   = 7'b0000100,
    S_CHK1  = 7'b0001000,
    S_RD2   = 7'b0010000,
    S_CHK2  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t      state;
  logic [1:0]  hash_mask;
  logic [GW-1:0] clr_cnt;

  // segment table and VSID allocator
  logic        seg_valid [16];
  logic [23:0] seg_vsid  [16];
  logic [23:0] vsid_counter;

  // item being worked on
  logic [1:0]  act;
  logic [23:0] vsid;
  logic [15:0] page;
  logic [19:0] frame;
  logic [GW-1:0] grp_addr;
  logic [1:0]  res_status;
  logic [19:0] res_page;

  // group memory
  pte_row_t    mem [GROUP_COUNT];
  pte_row_t    rd_row;
  pte_row_t    wr_row;
  logic        mem_we;
  logic        mem_re;
  logic [GW-1:0] mem_addr;

  logic        req_acc;
  logic        cfg_wr;
  logic [3:0]  seg;
  logic        in_seg_ok;
  logic [23:0] vsid_inc;
  logic        sec;
  logic [ENTRIES_PER_GROUP-1:0] cand;
  logic        hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [GW-1:0] idx_pri;
  logic [GW-1:0] idx_sec;

  // group index: low ten hash bits plus masked upper bits, cut to GW
  function automatic logic [GW-1:0] grp_index(input logic [19:0] h,
                                              input logic [1:0]  m);
    logic [19:0] full;
    full = h & {8'h00, m, 10'h3ff};
    return full[GW-1:0];
  endfunction

  assign idx_pri = grp_index(vsid[19:0] ^ {4'h0, page}, hash_mask);
  assign idx_sec = grp_index(~(vsid[19:0] ^ {4'h0, page}), hash_mask);

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HASH_MASK) ? {30'h0, hash_mask} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mask <= 2'd0;
    end else if (cfg_wr && paddr[2] == REG_HASH_MASK) begin
      hash_mask <= pwdata[1:0];
    end
  end

  // request side
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign seg       = req.virt_addr[31:28];
  assign in_seg_ok = seg_valid[seg];
  assign vsid_inc  = vsid_counter + 24'd1;
  assign sec       = (state == S_CHK2);

  // per-slot candidates: free slots for map, tag matches otherwise
  always_comb begin
    for (int i = 0; i < ENTRIES_PER_GROUP; i++) begin
      if (act == ACT_MAP) begin
        cand[i] = !rd_row[i].valid;
      end else begin
        cand[i] = rd_row[i].valid && rd_row[i].vsid == vsid &&
                  rd_row[i].sec == sec && rd_row[i].api == page[15:10];
      end
    end
  end

  // lowest candidate slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES_PER_GROUP - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // modified row for write-back
  always_comb begin
    wr_row = rd_row;
    if (act == ACT_MAP) begin
      wr_row[hit_idx] = '{valid: 1'b1, vsid: vsid, sec: sec,
                          api: page[15:10], frame: frame};
    end else begin
      wr_row[hit_idx].valid = 1'b0;
    end
  end

  // memory port control
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = grp_addr;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      S_RD1: begin
        mem_re   = 1'b1;
        mem_addr = idx_pri;
      end
      S_RD2: begin
        mem_re   = 1'b1;
        mem_addr = idx_sec;
      end
      S_CHK1, S_CHK2: begin
        mem_we = hit && act != ACT_RESOLVE;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= (state == S_CLEAR) ? '0 : wr_row;
    end
    if (mem_re) begin
      rd_row <= mem[mem_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      vsid_counter <= VSID_RESET;
      rsp.valid    <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        seg_valid[i] <= 1'b0;
      end
    end else begin
      // output register: load from S_OUT once free, else drop on hand-over
      if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            act        <= req.action;
            page       <= req.virt_addr[27:12];
            frame      <= req.phys_page;
            res_status <= ST_MISS;
            res_page   <= '0;
            if (req.action == ACT_MAP && !in_seg_ok) begin
              vsid_counter  <= vsid_inc;
              seg_vsid[seg] <= vsid_inc;
              seg_valid[seg] <= 1'b1;
              vsid          <= vsid_inc;
            end else begin
              vsid <= seg_vsid[seg];
            end
            if (req.action == ACT_MAP ||
                ((req.action == ACT_UNMAP || req.action == ACT_RESOLVE) &&
                 in_seg_ok)) begin
              state <= S_RD1;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_RD1: begin
          grp_addr <= idx_pri;
          state    <= S_CHK1;
        end
        S_RD2: begin
          grp_addr <= idx_sec;
          state    <= S_CHK2;
        end
        S_CHK1, S_CHK2: begin
          if (hit) begin
            res_status <= ST_OK;
            if (act == ACT_RESOLVE) begin
              res_page <= rd_row[hit_idx].frame;
            end
            state <= S_OUT;
          end else if (state == S_CHK1) begin
            state <= S_RD2;
          end else begin
            res_status <= (act == ACT_MAP) ? ST_FULL : ST_MISS;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          // hand over once the output register is free
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
      rsp.status      <= res_status;
      rsp.result_page <= res_page;
    end
  end

  // checks
  `HPT_ASSERT(a_no_req_in_clear, clk, rst, (state != S_CLEAR) || !req.ready,
              "request taken during clearing pass")
  `HPT_ASSERT(a_vsid_only_on_map, clk, rst,
              $stable(vsid_counter) || $past(rst) ||
              $past(req_acc && req.action == ACT_MAP),
              "VSID counter moved without a map request")
  `HPT_ASSERT_NEXT(a_write_means_ok, clk, rst, mem_we && state != S_CLEAR,
                   state == S_OUT && res_status == ST_OK,
                   "group write-back without a successful result")
  `HPT_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_acc, !req.ready,
                   "ready held after a request was accepted")

endmodule
`default_nettype wire

### tb/tb_hashed_page_table_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of hashed_page_table_engine_top: map, unmap and resolve
// words are scored against a page-table model kept inside the bench.
// Depends on hpt_pkg, the hpt_req_if / hpt_rsp_if interfaces and the engine RTL.
module tb_hashed_page_table_engine_top;
  import hpt_pkg::*;

  localparam int EIB          = EXTRA_INDEX_BITS_DEF;
  localparam int GROUPS       = 1 << (LOW_INDEX_BITS + EIB);
  localparam int PTE_COUNT    = GROUPS * ENTRIES_PER_GROUP;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_AT      = 520;   // accepted words before the long response hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 300;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] va;
    logic [19:0] frame;
  } pt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] frame;
  } pt_ans_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata, prdata;

  hpt_req_if req_ch ();
  hpt_rsp_if rsp_ch ();

  hashed_page_table_engine_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Shadow page table
  logic        seg_live [16];
  logic [23:0] seg_vsid [16];
  logic [23:0] vsid_last;
  pte_t        pte_mem  [PTE_COUNT];
  logic [1:0]  cfg_mask;

  pt_req_t req_backlog [$];
  pt_ans_t answer_q    [$];

  int      mismatch_cnt = 0;
  int      accepted_cnt = 0;
  int      cycle_cnt    = 0;
  int      burst_left, gap_left;
  int      hold_left;
  bit      hold_armed;
  int      ready_pct;
  int      pat_cnt;
  pt_req_t drv_word, seen_word;
  pt_ans_t want_ans, got_ans;

  task automatic model_reset();
    for (int k = 0; k < 16; k++) begin
      seg_live[k] = 1'b0;
      seg_vsid[k] = '0;
    end
    for (int k = 0; k < PTE_COUNT; k++) pte_mem[k] = '0;
    vsid_last = VSID_RESET;
    cfg_mask  = 2'd0;
  endtask

  // First entry of the primary or secondary group
  function automatic int unsigned group_base(logic [23:0] vsid, logic [15:0] page, logic sec);
    logic [19:0] h;
    logic [8:0]  up;
    int unsigned grp;
    h = vsid[19:0] ^ {4'h0, page};
    if (sec) h = ~h;
    up  = h[18:10] & 9'(cfg_mask) & 9'((1 << EIB) - 1);
    grp = (int'(h[9:0]) | (int'(up) << LOW_INDEX_BITS)) & (GROUPS - 1);
    return grp * ENTRIES_PER_GROUP;
  endfunction

  // Apply one request to the shadow table and work out its answer
  task automatic hpt_apply(input pt_req_t rq, output pt_ans_t ans);
    logic [3:0]  seg;
    logic [15:0] page;
    logic [23:0] vsid;
    int unsigned base;
    logic        done;
    pte_t        e;
    seg        = rq.va[31:28];
    page       = rq.va[27:12];
    ans.status = ST_MISS;
    ans.frame  = '0;
    done       = 1'b0;
    if (rq.action == ACT_MAP) begin
      // new segment takes the next VSID, even if the map then fails
      if (!seg_live[seg]) begin
        vsid_last     = vsid_last + 24'd1;
        seg_vsid[seg] = vsid_last;
        seg_live[seg] = 1'b1;
      end
      vsid       = seg_vsid[seg];
      ans.status = ST_FULL;
      for (int s = 0; s < 2 && !done; s++) begin
        base = group_base(vsid, page, s[0]);
        for (int i = 0; i < ENTRIES_PER_GROUP && !done; i++) begin
          if (!pte_mem[base + i].valid) begin
            e.valid = 1'b1;
            e.vsid  = vsid;
            e.sec   = s[0];
            e.api   = page[15:10];
            e.frame = rq.frame;
            pte_mem[base + i] = e;
            ans.status = ST_OK;
            done = 1'b1;
          end
        end
      end
    end else if ((rq.action == ACT_UNMAP || rq.action == ACT_RESOLVE) && seg_live[seg]) begin
      vsid = seg_vsid[seg];
      for (int s = 0; s < 2 && !done; s++) begin
        base = group_base(vsid, page, s[0]);
        for (int i = 0; i < ENTRIES_PER_GROUP && !done; i++) begin
          e = pte_mem[base + i];
          if (e.valid && e.vsid == vsid && e.sec == s[0] && e.api == page[15:10]) begin
            done = 1'b1;
            ans.status = ST_OK;
            if (rq.action == ACT_UNMAP) pte_mem[base + i].valid = 1'b0;
            else ans.frame = e.frame;
          end
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    if (mismatch_cnt < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    mismatch_cnt++;
  endtask

  // Request driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        drv_word = req_backlog.pop_front();
        req_ch.action    <= drv_word.action;
        req_ch.virt_addr <= drv_word.va;
        req_ch.phys_page <= drv_word.frame;
        req_ch.valid     <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Request monitor: every accepted word goes through the shadow table
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      seen_word.action = req_ch.action;
      seen_word.va     = req_ch.virt_addr;
      seen_word.frame  = req_ch.phys_page;
      hpt_apply(seen_word, want_ans);
      answer_q.push_back(want_ans);
      accepted_cnt++;
    end
  end

  // Long response hold-off, once, so the engine backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && accepted_cnt >= HOLD_AT) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response ready: random duty cycle, re-picked from four levels; low during the hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_pct    <= 100;
      pat_cnt      <= 0;
    end else begin
      pat_cnt <= pat_cnt + 1;
      if (pat_cnt % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 70;
          2: ready_pct <= 40;
          default: ready_pct <= 15;
        endcase
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Response checker against the oldest expected answer
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_ans.status = rsp_ch.status;
      got_ans.frame  = rsp_ch.result_page;
      if (answer_q.size() == 0) begin
        flag_mismatch("unexpected response", '0, 32'(got_ans));
      end else begin
        want_ans = answer_q.pop_front();
        if (got_ans.status !== want_ans.status)
          flag_mismatch("status", 32'(want_ans.status), 32'(got_ans.status));
        if (got_ans.frame !== want_ans.frame)
          flag_mismatch("result_page", 32'(want_ans.frame), 32'(got_ans.frame));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // APB write of hash_mask, then a read back of it
  task automatic cfg_write(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HASH_MASK, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_mask = value[1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {30'b0, cfg_mask})
      flag_mismatch("hash_mask readback", {30'b0, cfg_mask}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_req(input logic [1:0] action, input logic [31:0] va,
                           input logic [19:0] frame);
    pt_req_t rq;
    rq.action = action;
    rq.va     = va;
    rq.frame  = frame;
    req_backlog.push_back(rq);
  endtask

  // Random phase: mostly traffic on a few segments and pages so groups fill up
  task automatic load_random_phase(input int count);
    logic [3:0]  segs  [3];
    logic [15:0] pages [6];
    int          r;
    logic [1:0]  act;
    logic [31:0] va;
    foreach (segs[k]) segs[k] = 4'($urandom);
    foreach (pages[k]) pages[k] = 16'($urandom);
    repeat (count) begin
      r  = $urandom_range(0, 99);
      va = {segs[$urandom_range(0, 2)], pages[$urandom_range(0, 5)], 12'($urandom)};
      if (r < 40) act = ACT_MAP;
      else if (r < 62) act = ACT_RESOLVE;
      else if (r < 82) act = ACT_UNMAP;
      else begin
        // noise: any action, any address
        act = 2'($urandom);
        va  = $urandom;
      end
      queue_req(act, va, 20'($urandom));
    end
  endtask

  // Wait until every word is sent and answered; sampled away from the edge
  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || answer_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Stimulus sequence
  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_MAP;
    req_ch.virt_addr = '0;
    req_ch.phys_page = '0;
    rsp_ch.ready     = 1'b0;
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    cfg_write(32'h0);

    // invalid segment on resolve and unmap, unknown action
    queue_req(ACT_RESOLVE, 32'h0000_0000, 20'h00000);
    queue_req(ACT_UNMAP, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_req(ACT_UNUSED, 32'h1ABC_D000, 20'h12345);
    // duplicate maps of one page fill primary then secondary group, then ST_FULL
    queue_req(ACT_MAP, 32'h1ABC_D000, 20'hFFFFF);
    queue_req(ACT_MAP, 32'h1ABC_DFFF, 20'h00000);
    repeat (14) queue_req(ACT_MAP, {4'h1, 16'hABCD, 12'($urandom)}, 20'($urandom));
    queue_req(ACT_MAP, 32'h1ABC_D800, 20'hABCDE);
    // new segment whose VSID lands on the same full groups
    queue_req(ACT_MAP, 32'h2ABC_E000, 20'h5A5A5);
    queue_req(ACT_RESOLVE, 32'h1ABC_DFFF, 20'h00000);
    queue_req(ACT_UNMAP, 32'h1ABC_D123, 20'h00000);
    queue_req(ACT_RESOLVE, 32'h1ABC_D000, 20'h00000);
    queue_req(ACT_MAP, 32'h1ABC_D000, 20'h0F0F0);
    queue_req(ACT_MAP, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_req(ACT_RESOLVE, 32'hFFFF_F000, 20'h00000);
    queue_req(ACT_RESOLVE, 32'h2ABC_E000, 20'h00000);
    drain();

    // random phases over several mask settings, extremes included
    cfg_write({30'($urandom), 2'd3});
    load_random_phase(PHASE_WORDS);
    drain();
    cfg_write({30'($urandom), 2'd1});
    load_random_phase(PHASE_WORDS);
    drain();
    cfg_write({30'($urandom), 2'd2});
    load_random_phase(PHASE_WORDS);
    drain();
    cfg_write({30'($urandom), 2'd0});
    load_random_phase(PHASE_WORDS);
    drain();

    repeat (24) @(posedge clk);
    if (mismatch_cnt == 0 && answer_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
